FILE: hw/rtl/mppt_charge_controller_defines.svh
// Assertion macros for the charge controller RTL, used in the sequencer.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef MPPT_CHARGE_CONTROLLER_DEFINES_SVH
`define MPPT_CHARGE_CONTROLLER_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication
`define MPPT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("mppt charge controller: check failed");
// Next-cycle implication
`define MPPT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("mppt charge controller: check failed");
`else
`define MPPT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MPPT_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: hw/rtl/mppt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mppt_pkg;

	// Field widths
	localparam int VOLT_W      = 16;
	localparam int CUR_W       = 16;
	localparam int LIM_W       = 15;
	localparam int DUTY_CFG_W  = 10;
	localparam int ACT_W       = 3;
	localparam int POWER_W     = 32;
	localparam int CFG_ADDR_W  = 5;
	localparam int CFG_DATA_W  = 32;
	localparam int DUTY_BITS_DEF = 10;

	// Register reset values
	localparam logic [VOLT_W-1:0]     PANEL_PRESENT_RST   = 16'd13000;
	localparam logic [VOLT_W-1:0]     BATTERY_PRESENT_RST = 16'd11000;
	localparam logic [VOLT_W-1:0]     CV_VOLTAGE_RST      = 16'd12900;
	localparam logic [LIM_W-1:0]      FLOAT_CURRENT_RST   = 15'd100;
	localparam logic [LIM_W-1:0]      CC_CURRENT_RST      = 15'd1500;
	localparam logic [DUTY_CFG_W-1:0] DUTY_FLOOR_RST      = 10'd102;
	localparam logic [DUTY_CFG_W-1:0] DUTY_CEILING_RST    = 10'd921;

	// Register indexes (word address)
	typedef enum logic [2:0] {
		REG_PANEL_PRESENT   = 3'd0,
		REG_BATTERY_PRESENT = 3'd1,
		REG_CV_VOLTAGE      = 3'd2,
		REG_FLOAT_CURRENT   = 3'd3,
		REG_CC_CURRENT      = 3'd4,
		REG_DUTY_FLOOR      = 3'd5,
		REG_DUTY_CEILING    = 3'd6
	} reg_idx_t;

	// Action codes reported with each result
	typedef enum logic [ACT_W-1:0] {
		ACT_WAITING   = 3'd0,
		ACT_STARTED   = 3'd1,
		ACT_FLOAT_OFF = 3'd2,
		ACT_CV_LOWER  = 3'd3,
		ACT_MPPT_STEP = 3'd4,
		ACT_CC_LOWER  = 3'd5
	} action_t;

	typedef struct packed {
		logic [VOLT_W-1:0]     panel_present_mv;
		logic [VOLT_W-1:0]     battery_present_mv;
		logic [VOLT_W-1:0]     cv_voltage_mv;
		logic [LIM_W-1:0]      float_current_ma;
		logic [LIM_W-1:0]      cc_current_ma;
		logic [DUTY_CFG_W-1:0] duty_floor;
		logic [DUTY_CFG_W-1:0] duty_ceiling;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic calc;
		logic div_start;
		logic commit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_div;
		logic div_done;
	} sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/mppt_regs.sv
`timescale 1ns / 1ps
`default_nettype none
module mppt_regs import mppt_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic      [CFG_DATA_W-1:0] prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	// Write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.panel_present_mv   <= PANEL_PRESENT_RST;
			cfg_q.battery_present_mv <= BATTERY_PRESENT_RST;
			cfg_q.cv_voltage_mv      <= CV_VOLTAGE_RST;
			cfg_q.float_current_ma   <= FLOAT_CURRENT_RST;
			cfg_q.cc_current_ma      <= CC_CURRENT_RST;
			cfg_q.duty_floor         <= DUTY_FLOOR_RST;
			cfg_q.duty_ceiling       <= DUTY_CEILING_RST;
		end else if (wr_en) begin
			case (paddr[4:2])
				REG_PANEL_PRESENT:   cfg_q.panel_present_mv   <= pwdata[VOLT_W-1:0];
				REG_BATTERY_PRESENT: cfg_q.battery_present_mv <= pwdata[VOLT_W-1:0];
				REG_CV_VOLTAGE:      cfg_q.cv_voltage_mv      <= pwdata[VOLT_W-1:0];
				REG_FLOAT_CURRENT:   cfg_q.float_current_ma   <= pwdata[LIM_W-1:0];
				REG_CC_CURRENT:      cfg_q.cc_current_ma      <= pwdata[LIM_W-1:0];
				REG_DUTY_FLOOR:      cfg_q.duty_floor         <= pwdata[DUTY_CFG_W-1:0];
				REG_DUTY_CEILING:    cfg_q.duty_ceiling       <= pwdata[DUTY_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (paddr[4:2])
			REG_PANEL_PRESENT:   prdata = CFG_DATA_W'(cfg_q.panel_present_mv);
			REG_BATTERY_PRESENT: prdata = CFG_DATA_W'(cfg_q.battery_present_mv);
			REG_CV_VOLTAGE:      prdata = CFG_DATA_W'(cfg_q.cv_voltage_mv);
			REG_FLOAT_CURRENT:   prdata = CFG_DATA_W'(cfg_q.float_current_ma);
			REG_CC_CURRENT:      prdata = CFG_DATA_W'(cfg_q.cc_current_ma);
			REG_DUTY_FLOOR:      prdata = CFG_DATA_W'(cfg_q.duty_floor);
			REG_DUTY_CEILING:    prdata = CFG_DATA_W'(cfg_q.duty_ceiling);
			default:             prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

FILE: hw/rtl/mppt_div.sv
`timescale 1ns / 1ps
`default_nettype none
module mppt_div import mppt_pkg::*; #(
	parameter int N = VOLT_W + DUTY_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [N-1:0]      dividend,
	input  wire logic [VOLT_W-1:0] divisor,
	output logic      [N-1:0]      quotient,
	output logic                   done
);

	localparam int CNT_W = $clog2(N + 1);

	logic [N-1:0]      quo_q;
	logic [VOLT_W-1:0] rem_q;
	logic [VOLT_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [VOLT_W:0]   trial;
	logic              fits;

	// One quotient bit per cycle, restoring
	assign trial = {rem_q, quo_q[N-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(N);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[N-2:0], fits};
			rem_q <= fits ? VOLT_W'(trial - {1'b0, dvs_q}) : trial[VOLT_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign done     = (cnt_q == '0);

endmodule
`default_nettype wire

FILE: hw/rtl/mppt_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module mppt_dpath import mppt_pkg::*; #(
	parameter int DUTY_BITS = DUTY_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire cfg_t                      cfg,
	input  wire cmd_t                      cmd,
	output sts_t                           sts,
	input  wire logic        [VOLT_W-1:0]  panel_mv,
	input  wire logic signed [CUR_W-1:0]   panel_ma,
	input  wire logic        [VOLT_W-1:0]  battery_mv,
	input  wire logic signed [CUR_W-1:0]   battery_ma,
	output logic             [DUTY_BITS-1:0] duty,
	output logic                           switch_on,
	output logic                           set_up,
	output logic             [ACT_W-1:0]   action,
	output logic signed      [POWER_W-1:0] panel_power
);

	localparam int N  = VOLT_W + DUTY_BITS;
	localparam int DW = DUTY_CFG_W;
	localparam int CW = N + 2;
	localparam logic signed [DW+1:0] ONE_S = (DW+2)'(1);

	// Captured measurement
	logic        [VOLT_W-1:0]  pv_q;
	logic signed [CUR_W-1:0]   pi_q;
	logic        [VOLT_W-1:0]  bv_q;
	logic signed [CUR_W-1:0]   bi_q;
	logic signed [POWER_W-1:0] power_q;

	// Controller state
	logic                      setup_q;
	logic                      switch_q;
	logic        [DW-1:0]      duty_q;
	logic        [DW-1:0]      duty_before_q;
	logic signed [POWER_W-1:0] power_before_q;

	// Result beat payload
	logic        [ACT_W-1:0]   action_q;
	logic signed [POWER_W-1:0] res_power_q;

	logic signed [POWER_W-1:0] prod;
	logic        [N-1:0]       dividend;
	logic        [N-1:0]       quotient;
	logic                      div_done;
	logic                      panel_ok;
	logic                      batt_ok;

	logic                      setup_d;
	logic                      switch_d;
	logic        [DW-1:0]      duty_d;
	logic        [DW-1:0]      duty_before_d;
	logic signed [POWER_W-1:0] power_before_d;
	action_t                   action_d;
	logic signed [DW+1:0]      d_cur;
	logic signed [DW+1:0]      d_sel;

	function automatic logic [DW-1:0] clamp_duty(input logic signed [CW-1:0] d,
			input logic [DW-1:0] lo, input logic [DW-1:0] hi);
		logic signed [CW-1:0] hi_s;
		logic signed [CW-1:0] lo_s;
		hi_s = $signed({{(CW-DW){1'b0}}, hi});
		lo_s = $signed({{(CW-DW){1'b0}}, lo});
		if (d > hi_s)
			clamp_duty = hi;
		else if (d < lo_s)
			clamp_duty = lo;
		else
			clamp_duty = d[DW-1:0];
	endfunction

	// Capture the accepted beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pv_q <= panel_mv;
			pi_q <= panel_ma;
			bv_q <= battery_mv;
			bi_q <= battery_ma;
		end
	end

	// Panel power, registered after the multiplier; the product always fits 32 bits
	assign prod = $signed({{(POWER_W-VOLT_W){1'b0}}, pv_q}) *
		$signed({{(POWER_W-CUR_W){pi_q[CUR_W-1]}}, pi_q});

	always_ff @(posedge clk) begin
		if (cmd.calc)
			power_q <= prod;
	end

	// Start ratio: battery volts times full scale, over panel volts
	assign dividend = {bv_q, {DUTY_BITS{1'b0}}} - N'(bv_q);

	mppt_div #(
		.N(N)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (pv_q),
		.quotient (quotient),
		.done     (div_done)
	);

	assign panel_ok     = pv_q > cfg.panel_present_mv;
	assign batt_ok      = bv_q > cfg.battery_present_mv;
	assign sts.need_div = !setup_q && panel_ok && batt_ok;
	assign sts.div_done = div_done;

	// Charge rules
	always_comb begin
		setup_d        = setup_q;
		switch_d       = switch_q;
		duty_d         = duty_q;
		duty_before_d  = duty_before_q;
		power_before_d = power_before_q;
		action_d       = ACT_WAITING;
		d_cur          = $signed({2'b00, duty_q});
		d_sel          = d_cur;
		if (!setup_q) begin
			if (panel_ok && batt_ok) begin
				duty_d   = clamp_duty($signed({2'b00, quotient}), cfg.duty_floor,
					cfg.duty_ceiling);
				setup_d  = 1'b1;
				switch_d = 1'b1;
				action_d = ACT_STARTED;
			end
		end else begin
			if (!panel_ok || !batt_ok)
				setup_d = 1'b0;
			if (bv_q >= cfg.cv_voltage_mv) begin
				if (bi_q <= $signed({1'b0, cfg.float_current_ma})) begin
					switch_d = 1'b0;
					action_d = ACT_FLOAT_OFF;
				end else begin
					d_sel    = d_cur - ONE_S;
					action_d = ACT_CV_LOWER;
				end
			end else if (bi_q <= $signed({1'b0, cfg.cc_current_ma})) begin
				// Step the same way again if power rose with the last step
				if ((power_q >= power_before_q) == (duty_q >= duty_before_q))
					d_sel = d_cur + ONE_S;
				else
					d_sel = d_cur - ONE_S;
				duty_before_d  = duty_q;
				power_before_d = power_q;
				action_d       = ACT_MPPT_STEP;
			end else begin
				d_sel    = d_cur - ONE_S;
				action_d = ACT_CC_LOWER;
			end
			duty_d = clamp_duty({{(CW-DW-2){d_sel[DW+1]}}, d_sel}, cfg.duty_floor,
				cfg.duty_ceiling);
		end
	end

	// Commit state together with the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setup_q        <= 1'b0;
			switch_q       <= 1'b0;
			duty_q         <= '0;
			duty_before_q  <= '0;
			power_before_q <= '0;
		end else if (cmd.commit) begin
			setup_q        <= setup_d;
			switch_q       <= switch_d;
			duty_q         <= duty_d;
			duty_before_q  <= duty_before_d;
			power_before_q <= power_before_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			action_q    <= action_d;
			res_power_q <= power_q;
		end
	end

	assign duty        = DUTY_BITS'(duty_q);
	assign switch_on   = switch_q;
	assign set_up      = setup_q;
	assign action      = action_q;
	assign panel_power = res_power_q;

endmodule
`default_nettype wire

FILE: hw/rtl/mppt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "mppt_charge_controller_defines.svh"
module mppt_ctrl import mppt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic meas_valid,
	output logic      meas_stall,
	output logic      res_valid,
	input  wire logic res_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_CALC  = 4'b0010,
		S_DIV   = 4'b0100,
		S_APPLY = 4'b1000
	} ctrl_state_t;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        res_valid_q;

	// Sequence one measurement
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (meas_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CALC;
				end
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				if (sts.need_div) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					state_d = S_APPLY;
				end
			end
			S_DIV: begin
				if (sts.div_done)
					state_d = S_APPLY;
			end
			S_APPLY: begin
				// Hold until the output register is free
				if (!res_valid_q || !res_stall) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// Result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (cmd.commit)
			res_valid_q <= 1'b1;
		else if (!res_stall)
			res_valid_q <= 1'b0;
	end

	assign meas_stall = (state_q != S_IDLE);
	assign res_valid  = res_valid_q;

	`MPPT_ASSERT_NXT(a_accept_calc, clk, arst_n, meas_valid && !meas_stall, state_q == S_CALC)
	`MPPT_ASSERT_NXT(a_commit_valid, clk, arst_n, cmd.commit, res_valid_q)
	`MPPT_ASSERT_NXT(a_div_apply, clk, arst_n, state_q == S_DIV && sts.div_done, state_q == S_APPLY)
	`MPPT_ASSERT_IMP(a_commit_free, clk, arst_n, cmd.commit, !res_valid_q || !res_stall)

endmodule
`default_nettype wire

FILE: hw/rtl/mppt_charge_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// Perturb-and-observe solar charge controller with constant-current, constant-voltage
// and float rules. Each measurement beat (panel and battery volts and amps) yields one
// result beat: duty, switch level, setup flag, action code and panel power. A beat is
// loaded, then calculated, then applied in normal running; a beat that finds both
// sources present while the block is not set up computes the start duty with a
// one-bit-per-cycle restoring divider in a divide state before it is applied.
// A new measurement is taken the cycle after a result is registered, while that
// result waits to be taken; a stalled result holds the next one back.
// Thresholds and duty limits sit in an APB register bank at word addresses 0 to 6 and
// should be changed only while no measurement is in flight.
module mppt_charge_controller import mppt_pkg::*; #(
	parameter int DUTY_BITS = DUTY_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic        [CFG_ADDR_W-1:0] paddr,
	input  wire logic        [CFG_DATA_W-1:0] pwdata,
	output logic             [CFG_DATA_W-1:0] prdata,
	output logic                             pready,
	input  wire logic                        meas_valid,
	output logic                             meas_stall,
	input  wire logic        [VOLT_W-1:0]    panel_mv,
	input  wire logic signed [CUR_W-1:0]     panel_ma,
	input  wire logic        [VOLT_W-1:0]    battery_mv,
	input  wire logic signed [CUR_W-1:0]     battery_ma,
	output logic                             res_valid,
	input  wire logic                        res_stall,
	output logic             [DUTY_BITS-1:0] duty,
	output logic                             switch_on,
	output logic                             set_up,
	output logic             [ACT_W-1:0]     action,
	output logic signed      [POWER_W-1:0]   panel_power
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	mppt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mppt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.meas_valid (meas_valid),
		.meas_stall (meas_stall),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	mppt_dpath #(
		.DUTY_BITS(DUTY_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.sts         (sts),
		.panel_mv    (panel_mv),
		.panel_ma    (panel_ma),
		.battery_mv  (battery_mv),
		.battery_ma  (battery_ma),
		.duty        (duty),
		.switch_on   (switch_on),
		.set_up      (set_up),
		.action      (action),
		.panel_power (panel_power)
	);

endmodule
`default_nettype wire
